// ----- hdl/sms_sender_filter_parser_core_defines.svh -----
// Assertion macros shared by the SMS sender filter and parser.
`ifndef SMS_SENDER_FILTER_PARSER_CORE_DEFINES_SVH
`define SMS_SENDER_FILTER_PARSER_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define SSFP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ssfp: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define SSFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ssfp: next-cycle check failed");

`endif

// ----- hdl/ssfp_pkg.sv -----
// Shared constants and types for the SMS sender filter and parser.
package ssfp_pkg;

    localparam int MSG_BUFFER = 160;
    localparam int CHAR_W     = 8;
    localparam int NUM_CHARS  = 10;
    localparam int HALF_CHARS = 5;
    localparam int HALF_W     = HALF_CHARS * CHAR_W;
    localparam int CNT_W      = 4;
    localparam int LEN_W      = 8;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CHAR_W-1:0] QUOTE_CHAR   = 8'h22;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0a;
    localparam logic [CNT_W-1:0]  NUMBER_LEN   = 4'd13;
    localparam logic [CNT_W-1:0]  PREFIX_LEN   = 4'd3;
    localparam logic [LEN_W-1:0]  TEXT_CAP     = LEN_W'(MSG_BUFFER - 2);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HEAD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TAIL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HEAD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_TAIL = 3'd3;

    // Result kinds
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Per-character compare against both authorized numbers
    typedef struct packed {
        logic first;
        logic second;
    } t_match;

endpackage

// ----- hdl/sms_sender_filter_parser_core.sv -----
// Top level of the SMS sender filter and text parser.
//
// Takes one modem receive byte per request and sustains one byte per clock cycle
// while the result channel is not stalled: a byte enters an input register, is parsed
// by a single pass of compare and counter logic, and any result is then registered
// in an output register. The input register lets a new byte be taken while a result still
// waits downstream. Sender characters four to thirteen are compared one per byte
// against both configured numbers. Text is emitted one byte late so the byte before
// the closing line feed is dropped; at most MSG_BUFFER-2 characters are emitted and
// the end-of-message result carries the length, the sender match and a truncated flag.
// Configuration writes are taken at any time and should occur while the block is idle.
module sms_sender_filter_parser_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // byte input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [ssfp_pkg::CHAR_W-1:0]    i_rx_byte,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_kind,
    output logic [ssfp_pkg::CHAR_W-1:0]    o_text_char,
    output logic                           o_sender_ok,
    output logic [ssfp_pkg::LEN_W-1:0]     o_text_length,
    output logic                           o_truncated,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ssfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ssfp_pkg::HALF_W-1:0]    i_cfg_data
);
    import ssfp_pkg::*;

    `include "sms_sender_filter_parser_core_defines.svh"

    localparam logic [1:0] PH_WAIT_QUOTE = 2'd0;
    localparam logic [1:0] PH_NUMBER     = 2'd1;
    localparam logic [1:0] PH_WAIT_LF    = 2'd2;
    localparam logic [1:0] PH_TEXT       = 2'd3;

    // configuration
    logic [HALF_W-1:0] r_first_head, r_first_tail, r_second_head, r_second_tail;

    // input register
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_byte;

    // parse state
    logic [1:0]        r_phase, n_phase;
    logic [CNT_W-1:0]  r_num_count, n_num_count;
    logic              r_match_first, n_match_first;
    logic              r_match_second, n_match_second;
    logic [CHAR_W-1:0] r_held_char, n_held_char;
    logic              r_held_valid, n_held_valid;
    logic [LEN_W-1:0]  r_text_count, n_text_count;
    logic              r_overflow, n_overflow;

    // output register
    logic              r_out_valid;
    logic              r_kind, n_kind;
    logic [CHAR_W-1:0] r_text_char, n_text_char;
    logic              r_sender_ok, n_sender_ok;
    logic [LEN_W-1:0]  r_text_length, n_text_length;
    logic              r_truncated, n_truncated;
    logic              n_has_result;

    logic              advance;
    logic [CNT_W-1:0]  char_pos;
    t_match            char_equal;

    // Handshakes
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_head  <= '0;
            r_first_tail  <= '0;
            r_second_head <= '0;
            r_second_tail <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FIRST_HEAD:  r_first_head  <= i_cfg_data;
                CFG_FIRST_TAIL:  r_first_tail  <= i_cfg_data;
                CFG_SECOND_HEAD: r_second_head <= i_cfg_data;
                CFG_SECOND_TAIL: r_second_tail <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the accepted byte until the parser takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Compare the current number byte against both authorized numbers
    assign char_pos = r_num_count - PREFIX_LEN;

    ssfp_sender_match u_match (
        .i_first_head  (r_first_head),
        .i_first_tail  (r_first_tail),
        .i_second_head (r_second_head),
        .i_second_tail (r_second_tail),
        .i_char_pos    (char_pos),
        .i_byte        (r_in_byte),
        .o_equal       (char_equal)
    );

    // Parse one byte
    always_comb begin
        n_phase        = r_phase;
        n_num_count    = r_num_count;
        n_match_first  = r_match_first;
        n_match_second = r_match_second;
        n_held_char    = r_held_char;
        n_held_valid   = r_held_valid;
        n_text_count   = r_text_count;
        n_overflow     = r_overflow;
        n_has_result   = 1'b0;
        n_kind         = KIND_TEXT;
        n_text_char    = '0;
        n_sender_ok    = 1'b0;
        n_text_length  = '0;
        n_truncated    = 1'b0;
        unique case (r_phase)
            PH_WAIT_QUOTE: begin
                if (r_in_byte == QUOTE_CHAR) begin
                    n_phase        = PH_NUMBER;
                    n_num_count    = '0;
                    n_match_first  = 1'b1;
                    n_match_second = 1'b1;
                end
            end
            PH_NUMBER: begin
                if (r_num_count < NUMBER_LEN) begin
                    if (r_num_count >= PREFIX_LEN) begin
                        if (!char_equal.first)  n_match_first  = 1'b0;
                        if (!char_equal.second) n_match_second = 1'b0;
                    end
                    n_num_count = r_num_count + CNT_W'(1);
                end else begin
                    n_phase = PH_WAIT_LF;
                end
            end
            PH_WAIT_LF: begin
                if (r_in_byte == NEWLINE_CHAR) begin
                    n_phase      = PH_TEXT;
                    n_held_valid = 1'b0;
                    n_text_count = '0;
                    n_overflow   = 1'b0;
                end
            end
            default: begin
                if (r_in_byte == NEWLINE_CHAR) begin
                    // close the message and clear for the next one
                    n_has_result   = 1'b1;
                    n_kind         = KIND_END;
                    n_sender_ok    = r_match_first || r_match_second;
                    n_text_length  = r_text_count;
                    n_truncated    = r_overflow;
                    n_phase        = PH_WAIT_QUOTE;
                    n_num_count    = '0;
                    n_match_first  = 1'b1;
                    n_match_second = 1'b1;
                    n_held_char    = '0;
                    n_held_valid   = 1'b0;
                    n_text_count   = '0;
                    n_overflow     = 1'b0;
                end else if (r_held_valid) begin
                    // emit the held byte or drop it past capacity
                    n_held_char = r_in_byte;
                    if (r_text_count < TEXT_CAP) begin
                        n_text_count = r_text_count + LEN_W'(1);
                        n_has_result = 1'b1;
                        n_text_char  = r_held_char;
                    end else begin
                        n_overflow = 1'b1;
                    end
                end else begin
                    n_held_char  = r_in_byte;
                    n_held_valid = 1'b1;
                end
            end
        endcase
    end

    // Advance parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_WAIT_QUOTE;
            r_num_count    <= '0;
            r_match_first  <= 1'b1;
            r_match_second <= 1'b1;
            r_held_char    <= '0;
            r_held_valid   <= 1'b0;
            r_text_count   <= '0;
            r_overflow     <= 1'b0;
        end else if (advance) begin
            r_phase        <= n_phase;
            r_num_count    <= n_num_count;
            r_match_first  <= n_match_first;
            r_match_second <= n_match_second;
            r_held_char    <= n_held_char;
            r_held_valid   <= n_held_valid;
            r_text_count   <= n_text_count;
            r_overflow     <= n_overflow;
        end
    end

    // Load or drain the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && n_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_has_result) begin
            r_kind        <= n_kind;
            r_text_char   <= n_text_char;
            r_sender_ok   <= n_sender_ok;
            r_text_length <= n_text_length;
            r_truncated   <= n_truncated;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_text_char   = r_text_char;
    assign o_sender_ok   = r_sender_ok;
    assign o_text_length = r_text_length;
    assign o_truncated   = r_truncated;

    // Checks
    `SSFP_ASSERT_SAME(a_count_cap, 1'b1, r_text_count <= TEXT_CAP)
    `SSFP_ASSERT_SAME(a_num_count_range, r_phase == PH_NUMBER, r_num_count <= NUMBER_LEN)
    `SSFP_ASSERT_SAME(a_end_no_char, o_out_valid && (o_kind == KIND_END), o_text_char == '0)
    `SSFP_ASSERT_NEXT(a_end_clears, advance && n_has_result && (n_kind == KIND_END),
        (r_phase == PH_WAIT_QUOTE) && !r_held_valid && (r_text_count == '0))

endmodule

// ----- hdl/ssfp_sender_match.sv -----
// Compares one sender number byte with the matching character of both authorized numbers.
module ssfp_sender_match (
    input  logic [ssfp_pkg::HALF_W-1:0] i_first_head,
    input  logic [ssfp_pkg::HALF_W-1:0] i_first_tail,
    input  logic [ssfp_pkg::HALF_W-1:0] i_second_head,
    input  logic [ssfp_pkg::HALF_W-1:0] i_second_tail,
    input  logic [ssfp_pkg::CNT_W-1:0]  i_char_pos,
    input  logic [ssfp_pkg::CHAR_W-1:0] i_byte,
    output ssfp_pkg::t_match            o_equal
);
    import ssfp_pkg::*;

    logic [NUM_CHARS-1:0][CHAR_W-1:0] first_chars;
    logic [NUM_CHARS-1:0][CHAR_W-1:0] second_chars;
    logic [CHAR_W-1:0]                first_sel;
    logic [CHAR_W-1:0]                second_sel;

    // Split each number into characters, first character in the high byte
    always_comb begin
        for (int k = 0; k < HALF_CHARS; k++) begin
            first_chars[k]               = i_first_head[(HALF_CHARS-1-k)*CHAR_W +: CHAR_W];
            first_chars[k+HALF_CHARS]    = i_first_tail[(HALF_CHARS-1-k)*CHAR_W +: CHAR_W];
            second_chars[k]              = i_second_head[(HALF_CHARS-1-k)*CHAR_W +: CHAR_W];
            second_chars[k+HALF_CHARS]   = i_second_tail[(HALF_CHARS-1-k)*CHAR_W +: CHAR_W];
        end
    end

    // Select the character at the current position; out-of-range positions unused
    always_comb begin
        if (i_char_pos < CNT_W'(NUM_CHARS)) begin
            first_sel  = first_chars[i_char_pos];
            second_sel = second_chars[i_char_pos];
        end else begin
            first_sel  = '0;
            second_sel = '0;
        end
    end

    assign o_equal.first  = (i_byte == first_sel);
    assign o_equal.second = (i_byte == second_sel);

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the SMS sender filter and parser: random byte traffic checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import ssfp_pkg::*;

    localparam int          LONG_HOLD       = 150;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          PHASE_BUDGET    = 30;
    localparam logic [7:0]  CARRIAGE_RETURN = 8'h0d;
    localparam logic [HALF_W-1:0] ALL_ONES  = '1;

    typedef enum logic [1:0] {SEEK_QUOTE, TAKE_NUMBER, SEEK_LF, TAKE_TEXT} t_parse_phase;

    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] text_char;
        logic              sender_ok;
        logic [LEN_W-1:0]  text_length;
        logic              truncated;
    } t_sms_result;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [CHAR_W-1:0]    i_rx_byte   = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [HALF_W-1:0]    i_cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_kind;
    logic [CHAR_W-1:0]    o_text_char;
    logic                 o_sender_ok;
    logic [LEN_W-1:0]     o_text_length;
    logic                 o_truncated;
    logic                 o_cfg_ready;

    // Predictor state: authorized numbers and message parse progress
    logic [HALF_W-1:0] auth_head [2] = '{'0, '0};
    logic [HALF_W-1:0] auth_tail [2] = '{'0, '0};
    t_parse_phase      phase         = SEEK_QUOTE;
    logic [CNT_W-1:0]  num_count     = '0;
    logic              hit_first     = 1'b1;
    logic              hit_second    = 1'b1;
    logic [CHAR_W-1:0] pending_char  = '0;
    logic              pending_valid = 1'b0;
    logic [LEN_W-1:0]  emitted       = '0;
    logic              dropped       = 1'b0;

    t_sms_result       expected_results [$];
    logic [CHAR_W-1:0] rx_pending [$];
    int                bytes_queued   = 0;
    int                bytes_issued   = 0;
    int                bytes_accepted = 0;
    int                fail_count     = 0;
    int                send_gap       = 0;
    int                stall_left     = 0;
    int                hold_order     = 0;
    int                hold_served    = 0;
    bit                calm_tail      = 1'b0;

    sms_sender_filter_parser_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_text_char   (o_text_char),
        .o_sender_ok   (o_sender_ok),
        .o_text_length (o_text_length),
        .o_truncated   (o_truncated),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Character pos (0..9) of authorized number w
    function automatic logic [CHAR_W-1:0] authorized_char(input int w, input int pos);
        logic [HALF_W-1:0] half;
        half = (pos < HALF_CHARS) ? auth_head[w] : auth_tail[w];
        return half[(HALF_CHARS - 1 - pos % HALF_CHARS) * CHAR_W +: CHAR_W];
    endfunction

    function automatic logic [CHAR_W-1:0] any_byte_but(input logic [CHAR_W-1:0] avoid);
        logic [CHAR_W-1:0] b;
        do b = CHAR_W'($urandom_range(0, 255)); while (b == avoid);
        return b;
    endfunction

    function automatic logic [HALF_W-1:0] random_digits();
        logic [HALF_W-1:0] v;
        v = '0;
        repeat (HALF_CHARS) v = {v[HALF_W-CHAR_W-1:0], CHAR_W'(8'h30 + $urandom_range(0, 9))};
        return v;
    endfunction

    // Advance the parse by one received byte and record any result it causes
    task automatic parse_rx_byte(input logic [CHAR_W-1:0] b);
        t_sms_result r;
        int          pos;
        r = '0;
        case (phase)
            SEEK_QUOTE: begin
                if (b == QUOTE_CHAR) begin
                    phase      = TAKE_NUMBER;
                    num_count  = '0;
                    hit_first  = 1'b1;
                    hit_second = 1'b1;
                end
            end
            TAKE_NUMBER: begin
                if (num_count < NUMBER_LEN) begin
                    if (num_count >= PREFIX_LEN) begin
                        pos = int'(num_count - PREFIX_LEN);
                        if (b != authorized_char(0, pos)) hit_first = 1'b0;
                        if (b != authorized_char(1, pos)) hit_second = 1'b0;
                    end
                    num_count++;
                end else begin
                    phase = SEEK_LF;
                end
            end
            SEEK_LF: begin
                if (b == NEWLINE_CHAR) begin
                    phase         = TAKE_TEXT;
                    pending_valid = 1'b0;
                    emitted       = '0;
                    dropped       = 1'b0;
                end
            end
            TAKE_TEXT: begin
                if (b == NEWLINE_CHAR) begin
                    r.kind        = KIND_END;
                    r.sender_ok   = hit_first | hit_second;
                    r.text_length = emitted;
                    r.truncated   = dropped;
                    expected_results.push_back(r);
                    phase         = SEEK_QUOTE;
                    num_count     = '0;
                    hit_first     = 1'b1;
                    hit_second    = 1'b1;
                    pending_char  = '0;
                    pending_valid = 1'b0;
                    emitted       = '0;
                    dropped       = 1'b0;
                end else if (pending_valid) begin
                    // emit the held byte, one byte late
                    r.kind      = KIND_TEXT;
                    r.text_char = pending_char;
                    pending_char = b;
                    if (emitted < TEXT_CAP) begin
                        emitted++;
                        expected_results.push_back(r);
                    end else begin
                        dropped = 1'b1;
                    end
                end else begin
                    pending_char  = b;
                    pending_valid = 1'b1;
                end
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Take requests on the rising edge: predict accepted bytes, check delivered results
    always @(posedge i_clk) begin
        t_sms_result want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                parse_rx_byte(i_rx_byte);
                bytes_accepted++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no expectation waiting: kind %0d char %0d",
                           o_kind, o_text_char);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("kind", 8'(want.kind), 8'(o_kind));
                    compare_field("text_char", want.text_char, o_text_char);
                    compare_field("sender_ok", 8'(want.sender_ok), 8'(o_sender_ok));
                    compare_field("text_length", want.text_length, o_text_length);
                    compare_field("truncated", 8'(want.truncated), 8'(o_truncated));
                end
            end
        end
    end

    // Byte driver: hold an offered byte until taken, else advance or idle for a burst
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && bytes_issued != bytes_accepted)) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (rx_pending.size() > 0 && (calm_tail || $urandom_range(0, 7) != 0)) begin
                i_in_valid <= 1'b1;
                i_rx_byte  <= rx_pending.pop_front();
                bytes_issued++;
            end else begin
                if (rx_pending.size() > 0) send_gap = $urandom_range(0, 18);
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result sink: random stall bursts, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_served != hold_order) begin
            hold_served = hold_order;
            stall_left  = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 18);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic push_rx(input logic [CHAR_W-1:0] b);
        rx_pending.push_back(b);
        bytes_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_FIRST_HEAD:  auth_head[0] = data;
            CFG_FIRST_TAIL:  auth_tail[0] = data;
            CFG_SECOND_HEAD: auth_head[1] = data;
            CFG_SECOND_TAIL: auth_tail[1] = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every byte is taken and every result delivered, then let the pipe drain
    task automatic settle_idle();
        while (rx_pending.size() != 0 || bytes_issued != bytes_accepted ||
               expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Queue one well-formed message; text_len counts the bytes before the closing line feed
    task automatic queue_message(input int text_len);
        logic [CHAR_W-1:0] number [NUM_CHARS];
        int pick, w, k;
        pick = $urandom_range(0, 99);
        w    = $urandom_range(0, 1);
        for (k = 0; k < NUM_CHARS; k++)
            number[k] = (pick < 80) ? authorized_char(w, k) : CHAR_W'($urandom_range(0, 255));
        // near miss: flip one bit of one character
        if (pick >= 60 && pick < 80) begin
            k = $urandom_range(0, NUM_CHARS - 1);
            number[k] ^= CHAR_W'(1 << $urandom_range(0, 7));
        end
        repeat ($urandom_range(0, 2)) push_rx(any_byte_but(QUOTE_CHAR));
        push_rx(QUOTE_CHAR);
        repeat (PREFIX_LEN) push_rx(CHAR_W'($urandom_range(0, 255)));
        for (k = 0; k < NUM_CHARS; k++) push_rx(number[k]);
        push_rx(($urandom_range(0, 3) == 0) ? CHAR_W'($urandom_range(0, 255)) : QUOTE_CHAR);
        repeat ($urandom_range(0, 4)) push_rx(any_byte_but(NEWLINE_CHAR));
        push_rx(NEWLINE_CHAR);
        for (k = 0; k < text_len; k++) begin
            if (k == text_len - 1 && $urandom_range(0, 3) != 0)
                push_rx(CARRIAGE_RETURN);
            else if ($urandom_range(0, 15) == 0)
                push_rx(QUOTE_CHAR);
            else
                push_rx(any_byte_but(NEWLINE_CHAR));
        end
        push_rx(NEWLINE_CHAR);
    endtask

    // Idle the block, load both numbers, then queue messages mixed with noise
    task automatic run_phase(input logic [HALF_W-1:0] h0, input logic [HALF_W-1:0] t0,
                             input logic [HALF_W-1:0] h1, input logic [HALF_W-1:0] t1,
                             input int long_len, input bit long_hold);
        int start;
        settle_idle();
        write_reg(CFG_FIRST_HEAD, h0);
        write_reg(CFG_FIRST_TAIL, t0);
        write_reg(CFG_SECOND_HEAD, h1);
        write_reg(CFG_SECOND_TAIL, t1);
        start = bytes_queued;
        if (long_len > 0) queue_message(long_len);
        if (long_hold) hold_order++;
        while (bytes_queued - start < PHASE_BUDGET + long_len) begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 12)) push_rx(CHAR_W'($urandom_range(0, 255)));
            else
                queue_message(($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
                                                          : $urandom_range(0, 12));
        end
    endtask

    initial begin
        logic [HALF_W-1:0] h, t;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes while waiting, all-zero number against reset registers,
        // zero, all-ones and quote bytes as text, trailing carriage return dropped
        push_rx(8'h00);
        push_rx(8'hff);
        push_rx(QUOTE_CHAR);
        push_rx("+");
        push_rx("9");
        push_rx("1");
        repeat (NUM_CHARS) push_rx(8'h00);
        push_rx(QUOTE_CHAR);
        push_rx(NEWLINE_CHAR);
        push_rx(8'h00);
        push_rx(8'hff);
        push_rx(QUOTE_CHAR);
        push_rx(CARRIAGE_RETURN);
        push_rx(NEWLINE_CHAR);

        run_phase(ALL_ONES, ALL_ONES, '0, '0, 0, 1'b0);
        run_phase(random_digits(), random_digits(), random_digits(), random_digits(),
                  int'(TEXT_CAP) + 1, 1'b1);
        run_phase(random_digits(), random_digits(), random_digits(), random_digits(), 0, 1'b0);
        run_phase('0, ALL_ONES, ALL_ONES, '0, $urandom_range(int'(TEXT_CAP) + 2, 175), 1'b0);
        h = HALF_W'({$urandom(), $urandom()});
        t = HALF_W'({$urandom(), $urandom()});
        run_phase(h, t, h, t, 0, 1'b0);
        run_phase(random_digits(), random_digits(), random_digits(), random_digits(), 0, 1'b0);
        calm_tail = 1'b1;
        run_phase(random_digits(), random_digits(), random_digits(), random_digits(), 0, 1'b0);
        settle_idle();

        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/ssfp_pkg.sv
hdl/ssfp_sender_match.sv
hdl/sms_sender_filter_parser_core.sv
sim/tb_top.sv
